// ===== rtl/assert_macros.svh =====
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== rtl/sbfp_pkg.sv =====
//------------------------------------------------------------------------------
// sbfp_pkg
// Shared types and constants of the serial bridge with flash port.
//------------------------------------------------------------------------------
`default_nettype none
package sbfp_pkg;
   typedef enum logic [2:0] {
      OP_BUS    = 3'd0,
      OP_FWRITE = 3'd1,
      OP_FREAD  = 3'd2,
      OP_HPUSH  = 3'd3,
      OP_HPOP   = 3'd4,
      OP_NONE   = 3'd5
   } op_type;

   typedef enum logic {
      CSR_MAKER = 1'b0,
      CSR_PART  = 1'b1
   } csr_index_type;

   localparam logic [3:0]  OPC_ID     = 4'h9;
   localparam logic [3:0]  OPC_POP    = 4'hA;
   localparam logic [3:0]  OPC_PUSH   = 4'hB;
   localparam logic [3:0]  OPC_ROOM   = 4'hC;
   localparam logic [3:0]  OPC_DATA   = 4'hD;
   localparam logic [15:0] REPLY_ID   = 16'h0470;
   localparam logic [15:0] REPLY_OK   = 16'h0400;
   localparam logic [15:0] REPLY_POP  = 16'h0800;
   localparam logic [18:0] UNLOCK_A   = 19'h05555;
   localparam logic [18:0] UNLOCK_B   = 19'h02AAA;
   localparam logic [7:0]  KEY_AA     = 8'hAA;
   localparam logic [7:0]  KEY_55     = 8'h55;
   localparam logic [7:0]  KEY_PROG   = 8'hA0;
   localparam logic [7:0]  KEY_IDIN   = 8'h90;
   localparam logic [7:0]  KEY_IDOUT  = 8'hF0;

   typedef struct packed {
      op_type      op;
      logic [15:0] word;
      logic [18:0] addr;
      logic [7:0]  data;
   } item_type;
endpackage
`default_nettype wire

// ===== rtl/serial_bridge_with_flash_port.sv =====
//------------------------------------------------------------------------------
// serial_bridge_with_flash_port
// Device side of a byte bridge with FIFOs and a flash port.
//------------------------------------------------------------------------------
// channel  dir  handshake              payload
// req      in   req_tvalid/req_tready  req_tdata
// rsp      out  rsp_tvalid/rsp_tready  rsp_tdata
// csr      in   csr_we                 csr_index, csr_wdata
// An item passes the back via ST_EXEC, then ST_READ for a FIFO or flash read
// (registered memory read port), then ST_HOLD, where the result waits for rsp_tready.
// A two-entry queue lets the front accept while the back works.
// Reset is synchronous; no clearing pass is needed.
//------------------------------------------------------------------------------
`default_nettype none
module serial_bridge_with_flash_port #(
   parameter int FIFO_DEPTH  = 16,
   parameter int FLASH_BYTES = 524288
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // operation, command_word, flash_address, flash_data, host_byte
   input  wire  [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // reply_word, flash_read_data, host_byte_out, host_byte_valid, host_accepted
   output logic [39:0] rsp_tdata,
   input  wire         csr_we,
   input  wire         csr_index,
   input  wire  [7:0]  csr_wdata
);
   logic q_valid, q_ready;
   sbfp_pkg::item_type q_item;

   sbfp_front u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .q_valid, .q_ready, .q_item
   );

   sbfp_back #(.FIFO_DEPTH(FIFO_DEPTH), .FLASH_BYTES(FLASH_BYTES)) u_back (
      .clock, .reset, .q_valid, .q_ready, .q_item,
      .csr_we, .csr_index, .csr_wdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );
endmodule
`default_nettype wire

// ===== rtl/sbfp_front.sv =====
//------------------------------------------------------------------------------
// sbfp_front
// Accepts request transactions, classifies them and queues them for the back.
//------------------------------------------------------------------------------
`default_nettype none
module sbfp_front (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_tvalid,
   output logic                     req_tready,
   input  wire  [55:0]              req_tdata,
   output logic                     q_valid,
   input  wire                      q_ready,
   output sbfp_pkg::item_type       q_item
);
   sbfp_pkg::item_type q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       wp_ff, wp_in, rp_ff, rp_in;
   sbfp_pkg::item_type cls;
   logic [2:0] raw;
   logic push, pop;

   always_comb begin
      raw = req_tdata[2:0];
      cls.word = req_tdata[18:3];
      cls.addr = req_tdata[37:19];
      cls.data = (raw == sbfp_pkg::OP_HPUSH) ? req_tdata[53:46] : req_tdata[45:38];
      if (raw > sbfp_pkg::OP_HPOP) cls.op = sbfp_pkg::OP_NONE;
      else cls.op = sbfp_pkg::op_type'(raw);
   end

   assign req_tready = cnt_ff != 2'd2;
   assign push = req_tvalid && req_tready;
   assign q_valid = cnt_ff != 2'd0;
   assign pop = q_valid && q_ready;
   assign q_item = q_ff[rp_ff];
   assign wp_in = wp_ff ^ push;
   assign rp_in = rp_ff ^ pop;
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= cls;
      if (reset) begin
         cnt_ff <= 2'd0;
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wp_ff <= wp_in;
         rp_ff <= rp_in;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/sbfp_back.sv =====
//------------------------------------------------------------------------------
// sbfp_back
// Executes queued items: FIFOs, unlock sequencer, flash memory, result register.
//------------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module sbfp_back #(
   parameter int FIFO_DEPTH  = 16,
   parameter int FLASH_BYTES = 524288
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 q_valid,
   output logic                q_ready,
   input  sbfp_pkg::item_type  q_item,
   input  wire                 csr_we,
   input  wire                 csr_index,
   input  wire  [7:0]          csr_wdata,
   output logic                rsp_tvalid,
   input  wire                 rsp_tready,
   output logic [39:0]         rsp_tdata
);
   localparam int PW = $clog2(FIFO_DEPTH);
   localparam int CW = $clog2(FIFO_DEPTH + 1);
   localparam int AW = $clog2(FLASH_BYTES);
   localparam logic [CW-1:0] FULL = CW'(FIFO_DEPTH);
   localparam logic [CW:0]   FULL_X = (CW+1)'(FIFO_DEPTH);
   localparam logic [PW-1:0] LAST = PW'(FIFO_DEPTH - 1);

   typedef enum logic [1:0] {ST_EXEC, ST_READ, ST_HOLD} st_type;
   typedef enum logic [1:0] {SRC_REG, SRC_RX, SRC_TX, SRC_FL} src_type;
   typedef enum logic [1:0] {UL_IDLE, UL_AA, UL_55, UL_ARMED} ul_type;

   logic [7:0] rx_mem [FIFO_DEPTH];
   logic [7:0] tx_mem [FIFO_DEPTH];
   logic [7:0] fl_mem [FLASH_BYTES];

   st_type st_ff, st_in;
   src_type src_ff, src_in;
   ul_type ul_ff, ul_in;
   logic [CW-1:0] rxc_ff, rxc_in, txc_ff, txc_in;
   logic [PW-1:0] rxr_ff, rxr_in, txr_ff, txr_in;
   logic idm_ff, idm_in;
   logic [7:0] mk_ff, mk_in, pt_ff, pt_in;
   logic [39:0] res_ff, res_in;
   logic [7:0] rd_ff;
   logic vld_ff, vld_in;

   logic rx_empty, tx_empty, rx_full, tx_full;
   logic [PW-1:0] rx_wa, tx_wa;
   logic [CW:0] rx_sum, tx_sum;
   logic [AW-1:0] fa;
   logic in_range;
   logic [3:0] opc;
   logic go;

   assign rx_empty = rxc_ff == '0;
   assign tx_empty = txc_ff == '0;
   assign rx_full = rxc_ff >= FULL;
   assign tx_full = txc_ff >= FULL;
   assign rx_sum = (CW+1)'(rxr_ff) + (CW+1)'(rxc_ff);
   assign tx_sum = (CW+1)'(txr_ff) + (CW+1)'(txc_ff);
   assign rx_wa = (rx_sum >= FULL_X) ? PW'(rx_sum - FULL_X) : PW'(rx_sum);
   assign tx_wa = (tx_sum >= FULL_X) ? PW'(tx_sum - FULL_X) : PW'(tx_sum);
   assign fa = AW'(q_item.addr);
   assign in_range = 20'(q_item.addr) < 20'(FLASH_BYTES);
   assign opc = q_item.word[15:12];
   assign q_ready = st_ff == ST_EXEC && !vld_ff;
   assign go = q_valid && q_ready;

   // result fields: reply [15:0], flash byte [23:16], host byte [31:24],
   // host valid [32], host accepted [33]
   assign rsp_tvalid = vld_ff;
   always_comb begin
      rsp_tdata = res_ff;
      unique case (src_ff)
         SRC_RX:  rsp_tdata[7:0] = rd_ff;
         SRC_TX:  rsp_tdata[31:24] = rd_ff;
         SRC_FL:  rsp_tdata[23:16] = rd_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (go && q_item.op == sbfp_pkg::OP_BUS && opc == sbfp_pkg::OPC_PUSH && !tx_full)
         tx_mem[tx_wa] <= q_item.word[11:4];
      if (go && q_item.op == sbfp_pkg::OP_HPUSH && !rx_full)
         rx_mem[rx_wa] <= q_item.data;
      if (go && q_item.op == sbfp_pkg::OP_FWRITE && ul_ff == UL_ARMED && in_range)
         fl_mem[fa] <= q_item.data;
      if (go) begin
         if (q_item.op == sbfp_pkg::OP_HPOP) rd_ff <= tx_mem[txr_ff];
         else if (q_item.op == sbfp_pkg::OP_BUS) rd_ff <= rx_mem[rxr_ff];
         else rd_ff <= fl_mem[fa];
      end
   end

   always_comb begin
      st_in = st_ff;
      src_in = src_ff;
      res_in = res_ff;
      vld_in = vld_ff;
      rxc_in = rxc_ff;
      txc_in = txc_ff;
      rxr_in = rxr_ff;
      txr_in = txr_ff;
      ul_in = ul_ff;
      idm_in = idm_ff;
      mk_in = mk_ff;
      pt_in = pt_ff;
      if (csr_we && csr_index == sbfp_pkg::CSR_MAKER) mk_in = csr_wdata;
      if (csr_we && csr_index == sbfp_pkg::CSR_PART) pt_in = csr_wdata;
      unique case (st_ff)
         ST_EXEC: if (go) begin
            res_in = '0;
            src_in = SRC_REG;
            st_in = ST_HOLD;
            unique case (q_item.op)
               sbfp_pkg::OP_BUS: begin
                  unique case (opc)
                     sbfp_pkg::OPC_ID: res_in[15:0] = sbfp_pkg::REPLY_ID;
                     sbfp_pkg::OPC_POP: if (!rx_empty) begin
                        res_in[15:0] = sbfp_pkg::REPLY_POP;
                        src_in = SRC_RX;
                        st_in = ST_READ;
                        rxc_in = rxc_ff - CW'(1);
                        rxr_in = (rxr_ff == LAST) ? '0 : rxr_ff + PW'(1);
                     end
                     sbfp_pkg::OPC_PUSH: if (!tx_full) begin
                        res_in[15:0] = sbfp_pkg::REPLY_OK;
                        txc_in = txc_ff + CW'(1);
                     end
                     sbfp_pkg::OPC_ROOM:
                        if (!tx_full) res_in[15:0] = sbfp_pkg::REPLY_OK;
                     sbfp_pkg::OPC_DATA:
                        if (!rx_empty) res_in[15:0] = sbfp_pkg::REPLY_OK;
                     default: ;
                  endcase
               end
               sbfp_pkg::OP_FWRITE: begin
                  if (ul_ff == UL_ARMED) ul_in = UL_IDLE;
                  else if (ul_ff == UL_AA && q_item.addr == sbfp_pkg::UNLOCK_B &&
                           q_item.data == sbfp_pkg::KEY_55) ul_in = UL_55;
                  else if (ul_ff == UL_55 && q_item.addr == sbfp_pkg::UNLOCK_A &&
                           q_item.data == sbfp_pkg::KEY_PROG) ul_in = UL_ARMED;
                  else if (ul_ff == UL_55 && q_item.addr == sbfp_pkg::UNLOCK_A &&
                           (q_item.data == sbfp_pkg::KEY_IDIN ||
                            q_item.data == sbfp_pkg::KEY_IDOUT)) begin
                     idm_in = q_item.data == sbfp_pkg::KEY_IDIN;
                     ul_in = UL_IDLE;
                  end else
                     ul_in = (q_item.addr == sbfp_pkg::UNLOCK_A &&
                              q_item.data == sbfp_pkg::KEY_AA) ? UL_AA : UL_IDLE;
               end
               sbfp_pkg::OP_FREAD: begin
                  if (idm_ff) res_in[23:16] = q_item.addr[0] ? pt_ff : mk_ff;
                  else if (in_range) begin
                     src_in = SRC_FL;
                     st_in = ST_READ;
                  end
               end
               sbfp_pkg::OP_HPUSH: if (!rx_full) begin
                  res_in[33] = 1'b1;
                  rxc_in = rxc_ff + CW'(1);
               end
               sbfp_pkg::OP_HPOP: if (!tx_empty) begin
                  res_in[32] = 1'b1;
                  src_in = SRC_TX;
                  st_in = ST_READ;
                  txc_in = txc_ff - CW'(1);
                  txr_in = (txr_ff == LAST) ? '0 : txr_ff + PW'(1);
               end
               default: ;
            endcase
         end
         ST_READ: st_in = ST_HOLD;
         ST_HOLD: begin
            if (!vld_ff) vld_in = 1'b1;
            else if (rsp_tready) begin
               vld_in = 1'b0;
               st_in = ST_EXEC;
            end
         end
         default: st_in = ST_EXEC;
      endcase
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (reset) begin
         st_ff <= ST_EXEC;
         vld_ff <= 1'b0;
         src_ff <= SRC_REG;
         rxc_ff <= '0; txc_ff <= '0; rxr_ff <= '0; txr_ff <= '0;
         ul_ff <= UL_IDLE; idm_ff <= 1'b0;
         mk_ff <= 8'hBF; pt_ff <= 8'hD7;
      end else begin
         st_ff <= st_in;
         vld_ff <= vld_in;
         src_ff <= src_in;
         rxc_ff <= rxc_in; txc_ff <= txc_in; rxr_ff <= rxr_in; txr_ff <= txr_in;
         ul_ff <= ul_in; idm_ff <= idm_in;
         mk_ff <= mk_in; pt_ff <= pt_in;
      end
   end

   `ASSERT_IMPL(a_rx_bound, clock, reset, rxc_ff <= FULL, "rx count overflow")
   `ASSERT_IMPL(a_tx_bound, clock, reset, txc_ff <= FULL, "tx count overflow")
   `ASSERT_IMPL(a_no_take, clock, reset, vld_ff |-> !q_ready, "item taken while result pending")
endmodule
`default_nettype wire
